// ===== sv/msc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msc_pkg
// Types, constants and helpers shared by the mse split criterion unit.
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam int MAX_SAMPLES_DEFAULT = 4096;
    localparam int WEIGHT_W            = 16;
    localparam int TARGET_W            = 16;
    localparam int POS_W               = 13;
    localparam int WTOT_W              = 36;
    localparam int OUT_W               = 64;
    localparam int WIDE_W              = 128;
    localparam int DVSR_W              = 64;
    localparam int ENTRY_W             = WEIGHT_W + TARGET_W;
    localparam int STATUS_W            = 2;

    localparam logic [WTOT_W-1:0] WTOT_RESET = WTOT_W'(256);
    localparam logic [OUT_W-1:0]  INT64_TOP  = {1'b0, {(OUT_W-1){1'b1}}};

    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LEFT_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RIGHT_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_CLAMPED     = 2'd3;

    localparam logic [1:0] SIDE_NODE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_ACC,
        ST_WALK_RD,
        ST_WALK_MUL,
        ST_WALK_ACC,
        ST_ISSUE,
        ST_WAIT,
        ST_LR,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        STEP_SS,
        STEP_QW,
        STEP_WW,
        STEP_VAR,
        STEP_T,
        STEP_IMP
    } step_t;

    typedef enum logic {
        ARITH_MUL,
        ARITH_DIV
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    function automatic logic [OUT_W-1:0] sat64(input logic [WIDE_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v[WIDE_W-1:OUT_W-1] != '0) begin
            r = INT64_TOP;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/msc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module msc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== sv/msc_arith.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msc_arith
// Shared multi-cycle unit: 64x64 multiply (one byte per cycle) and
// 128 by 64 restoring divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module msc_arith (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire msc_pkg::arith_req_t           req,
    input  wire logic [msc_pkg::WIDE_W-1:0]    a,
    input  wire logic [msc_pkg::DVSR_W-1:0]    b,
    output logic                               done,
    output logic      [msc_pkg::WIDE_W-1:0]    result
);

    logic                          busy_reg;
    logic                          done_reg;
    msc_pkg::arith_op_t            op_reg;
    logic [6:0]                    cnt_reg;
    logic [msc_pkg::WIDE_W-1:0]    res_reg;
    logic [msc_pkg::WIDE_W-1:0]    mcand_reg;
    logic [msc_pkg::DVSR_W-1:0]    b_reg;
    logic [msc_pkg::DVSR_W-1:0]    rem_reg;

    logic [msc_pkg::WIDE_W+7:0]    pp;
    logic [msc_pkg::DVSR_W:0]      r2;
    logic                          ge;
    logic [msc_pkg::DVSR_W:0]      r2_sub;
    logic [6:0]                    last;

    assign pp     = mcand_reg * b_reg[7:0];
    assign r2     = {rem_reg, res_reg[msc_pkg::WIDE_W-1]};
    assign ge     = r2 >= {1'b0, b_reg};
    assign r2_sub = r2 - {1'b0, b_reg};
    assign last   = (op_reg == msc_pkg::ARITH_MUL) ? 7'd7 : 7'd127;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == last) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            op_reg  <= req.op;
            cnt_reg <= '0;
            b_reg   <= b;
            rem_reg <= '0;
            if (req.op == msc_pkg::ARITH_MUL) begin
                res_reg   <= '0;
                mcand_reg <= {{(msc_pkg::WIDE_W-msc_pkg::DVSR_W){1'b0}},
                              a[msc_pkg::DVSR_W-1:0]};
            end else begin
                res_reg   <= a;
                mcand_reg <= '0;
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 7'd1;
            if (op_reg == msc_pkg::ARITH_MUL) begin
                res_reg   <= res_reg + pp[msc_pkg::WIDE_W-1:0];
                mcand_reg <= {mcand_reg[msc_pkg::WIDE_W-9:0], 8'd0};
                b_reg     <= {8'd0, b_reg[msc_pkg::DVSR_W-1:8]};
            end else begin
                rem_reg <= ge ? r2_sub[msc_pkg::DVSR_W-1:0] : r2[msc_pkg::DVSR_W-1:0];
                res_reg <= {res_reg[msc_pkg::WIDE_W-2:0], ge};
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

// ===== sv/mse_split_criterion_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mse_split_criterion_unit
// Weighted mean-squared-error split evaluator for regression trees.
// ----------------------------------------------------------------------------
// Input channel s_*: one transfer is a load (opcode 0) or a query (opcode 1).
// A load with first_of_node starts a new node; each load writes the sample
// store and updates the node sums, unless the store is full. Loads give no
// result. A query moves the split point, walking the store from the nearer
// end (one RAM read, two multiply stages per sample), then evaluates node,
// left and right sides on one shared arithmetic unit with byte-serial
// multiplies and bit-serial divides, nine multiplies and seven divides when
// no side is empty.
// Result channel m_*: one transfer per query from an output register; the
// input side reopens as soon as the result is registered. If the receiver
// stalls, the next query waits at its end for the output register to free.
// Reset clears node sums, split point, count and sets dataset weight to 1.0;
// the store itself needs no clearing. cfg_we writes dataset_weight_total;
// the user must do so only while the unit is idle, the unit does not enforce it.
// ----------------------------------------------------------------------------
module mse_split_criterion_unit #(
    parameter int MAX_NODE_SAMPLES = msc_pkg::MAX_SAMPLES_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [msc_pkg::WTOT_W-1:0]         cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_opcode,
    input  wire logic                               s_first_of_node,
    input  wire logic [msc_pkg::WEIGHT_W-1:0]       s_sample_weight,
    input  wire logic signed [msc_pkg::TARGET_W-1:0] s_target,
    input  wire logic [msc_pkg::POS_W-1:0]          s_split_position,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [msc_pkg::OUT_W-1:0]        m_parent_impurity,
    output logic signed [msc_pkg::OUT_W-1:0]        m_left_impurity,
    output logic signed [msc_pkg::OUT_W-1:0]        m_right_impurity,
    output logic signed [msc_pkg::OUT_W-1:0]        m_proxy_improvement,
    output logic signed [msc_pkg::OUT_W-1:0]        m_improvement,
    output logic [msc_pkg::STATUS_W-1:0]            m_status
);

    localparam int ADDR_W = $clog2(MAX_NODE_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_NODE_SAMPLES + 1);
    localparam int PW     = (CNT_W > msc_pkg::POS_W) ? CNT_W : msc_pkg::POS_W;
    localparam int W_W    = msc_pkg::WEIGHT_W + ADDR_W;
    localparam int S_W    = 2 * msc_pkg::WEIGHT_W + ADDR_W;
    localparam int Q_W    = 3 * msc_pkg::WEIGHT_W + ADDR_W;
    localparam int WIDE_W = msc_pkg::WIDE_W;
    localparam int OUT_W  = msc_pkg::OUT_W;

    msc_pkg::state_t state_reg, state_next;
    msc_pkg::step_t  step_reg, step_next;
    logic [1:0]      side_reg, side_next;

    logic [msc_pkg::WTOT_W-1:0] wtot_reg;

    logic [CNT_W-1:0]      cnt_reg, sp_reg, ptr_reg, pos_reg;
    logic [W_W-1:0]        nw_reg, lw_reg;
    logic signed [S_W-1:0] ns_reg, ls_reg;
    logic [Q_W-1:0]        nq_reg, lq_reg;
    logic                  fwd_reg, clamp_reg;
    logic [msc_pkg::STATUS_W-1:0] status_reg;

    logic [msc_pkg::WEIGHT_W-1:0]        opw_reg;
    logic signed [msc_pkg::TARGET_W-1:0] opy_reg;
    logic signed [32:0]                  wy_reg;
    logic [31:0]                         yy_reg;

    logic [WIDE_W-1:0] ss_reg, qw_reg, lr_reg;
    logic [63:0]       ww_reg;
    logic [OUT_W-1:0]  var_reg [3];
    logic [WIDE_W-1:0] t_reg [3];
    logic [OUT_W-1:0]  imp_reg;

    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_node_reg, m_left_reg, m_right_reg, m_proxy_reg, m_imp_reg;
    logic [msc_pkg::STATUS_W-1:0] m_status_reg;

    // sample store
    logic                         ram_we, ram_re;
    logic [ADDR_W-1:0]            ram_waddr, ram_raddr;
    logic [msc_pkg::ENTRY_W-1:0]  ram_rdata;

    // arithmetic unit
    msc_pkg::arith_req_t  a_req;
    logic [WIDE_W-1:0]    a_a;
    logic [63:0]          a_b;
    logic                 a_done;
    logic [WIDE_W-1:0]    a_res;

    logic                  in_xfer;
    logic [CNT_W-1:0]      cnt_eff;
    logic                  load_ok;
    logic [PW-1:0]         pos_ext, cnt_ext, sp_ext, pos_c;
    logic                  clamp_c, fwd_c;

    logic [msc_pkg::WEIGHT_W-1:0]        mul_w;
    logic signed [msc_pkg::TARGET_W-1:0] mul_y;
    logic signed [32:0]                  wy_c;
    logic signed [31:0]                  yy_c;
    logic [47:0]                         wyy_c;

    logic [W_W-1:0]        rw;
    logic signed [S_W-1:0] rs;
    logic [Q_W-1:0]        rq;
    logic [63:0]           sel_q, sel_w, sel_sa;
    logic signed [S_W-1:0] sel_s;
    logic [S_W-1:0]        sel_s_abs;
    logic                  w_zero;

    logic              imp_neg;
    logic [WIDE_W-1:0] imp_d, vdiff;
    logic [63:0]       wt64;
    logic [OUT_W-1:0]  imp_mag;

    logic out_load;

    msc_ram #(
        .WIDTH (msc_pkg::ENTRY_W),
        .DEPTH (MAX_NODE_SAMPLES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({s_target, s_sample_weight}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    msc_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (a_req),
        .a       (a_a),
        .b       (a_b),
        .done    (a_done),
        .result  (a_res)
    );

    assign s_ready = (state_reg == msc_pkg::ST_IDLE);
    assign in_xfer = s_valid && s_ready;

    // load path
    assign cnt_eff   = s_first_of_node ? '0 : cnt_reg;
    assign load_ok   = cnt_eff < CNT_W'(MAX_NODE_SAMPLES);
    assign ram_we    = in_xfer && (s_opcode == msc_pkg::OP_LOAD) && load_ok;
    assign ram_waddr = cnt_eff[ADDR_W-1:0];

    // query position
    assign pos_ext = PW'(s_split_position);
    assign cnt_ext = PW'(cnt_reg);
    assign sp_ext  = PW'(sp_reg);
    assign clamp_c = pos_ext > cnt_ext;
    assign pos_c   = clamp_c ? cnt_ext : pos_ext;
    assign fwd_c   = (pos_c >= sp_ext) && ((pos_c - sp_ext) <= (cnt_ext - pos_c));

    // store walk
    assign ram_re    = (state_reg == msc_pkg::ST_WALK_RD) && (ptr_reg != pos_reg);
    assign ram_raddr = fwd_reg ? ptr_reg[ADDR_W-1:0] : ADDR_W'(ptr_reg - CNT_W'(1));

    assign mul_w = (state_reg == msc_pkg::ST_WALK_MUL) ? ram_rdata[msc_pkg::WEIGHT_W-1:0]
                                                       : opw_reg;
    assign mul_y = (state_reg == msc_pkg::ST_WALK_MUL) ?
                   $signed(ram_rdata[msc_pkg::ENTRY_W-1:msc_pkg::WEIGHT_W]) : opy_reg;
    assign wy_c  = $signed({1'b0, mul_w}) * mul_y;
    assign yy_c  = mul_y * mul_y;
    assign wyy_c = opw_reg * yy_reg;

    // side operands
    assign rw = nw_reg - lw_reg;
    assign rs = ns_reg - ls_reg;
    assign rq = nq_reg - lq_reg;

    always_comb begin
        unique case (side_reg)
            msc_pkg::SIDE_NODE: begin
                sel_q = 64'(nq_reg);
                sel_w = 64'(nw_reg);
                sel_s = ns_reg;
            end
            msc_pkg::SIDE_LEFT: begin
                sel_q = 64'(lq_reg);
                sel_w = 64'(lw_reg);
                sel_s = ls_reg;
            end
            default: begin
                sel_q = 64'(rq);
                sel_w = 64'(rw);
                sel_s = rs;
            end
        endcase
    end

    assign sel_s_abs = sel_s[S_W-1] ? S_W'(-sel_s) : S_W'(sel_s);
    assign sel_sa    = 64'(sel_s_abs);
    assign w_zero    = (sel_w == '0);

    assign vdiff   = (qw_reg - ss_reg) << 8;
    assign imp_neg = lr_reg < t_reg[0];
    assign imp_d   = (imp_neg ? (t_reg[0] - lr_reg) : (lr_reg - t_reg[0])) << 8;
    assign wt64    = (wtot_reg == '0) ? 64'd1 : 64'(wtot_reg);
    assign imp_mag = msc_pkg::sat64(a_res);

    // arithmetic requests
    always_comb begin
        a_req.start = (state_reg == msc_pkg::ST_ISSUE);
        a_req.op    = msc_pkg::ARITH_MUL;
        a_a         = '0;
        a_b         = '0;
        unique case (step_reg)
            msc_pkg::STEP_SS: begin
                a_a = WIDE_W'(sel_sa);
                a_b = sel_sa;
            end
            msc_pkg::STEP_QW: begin
                a_a = WIDE_W'(sel_q);
                a_b = sel_w;
            end
            msc_pkg::STEP_WW: begin
                a_a = WIDE_W'(sel_w);
                a_b = sel_w;
            end
            msc_pkg::STEP_VAR: begin
                a_req.op = msc_pkg::ARITH_DIV;
                a_a      = vdiff;
                a_b      = ww_reg;
            end
            msc_pkg::STEP_T: begin
                a_req.op = msc_pkg::ARITH_DIV;
                a_a      = ss_reg;
                a_b      = sel_w;
            end
            default: begin
                a_req.op = msc_pkg::ARITH_DIV;
                a_a      = imp_d;
                a_b      = wt64;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        side_next  = side_reg;
        unique case (state_reg)
            msc_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (s_opcode == msc_pkg::OP_LOAD) begin
                        state_next = load_ok ? msc_pkg::ST_LD_MUL : msc_pkg::ST_IDLE;
                    end else begin
                        state_next = msc_pkg::ST_WALK_RD;
                    end
                end
            end
            msc_pkg::ST_LD_MUL:   state_next = msc_pkg::ST_LD_ACC;
            msc_pkg::ST_LD_ACC:   state_next = msc_pkg::ST_IDLE;
            msc_pkg::ST_WALK_RD: begin
                if (ptr_reg == pos_reg) begin
                    state_next = msc_pkg::ST_ISSUE;
                    step_next  = msc_pkg::STEP_SS;
                    side_next  = msc_pkg::SIDE_NODE;
                end else begin
                    state_next = msc_pkg::ST_WALK_MUL;
                end
            end
            msc_pkg::ST_WALK_MUL: state_next = msc_pkg::ST_WALK_ACC;
            msc_pkg::ST_WALK_ACC: state_next = msc_pkg::ST_WALK_RD;
            msc_pkg::ST_ISSUE:    state_next = msc_pkg::ST_WAIT;
            msc_pkg::ST_WAIT: begin
                if (a_done) begin
                    state_next = msc_pkg::ST_ISSUE;
                    case (step_reg)
                        msc_pkg::STEP_SS: begin
                            if (w_zero) begin
                                if (side_reg == msc_pkg::SIDE_RIGHT) begin
                                    state_next = msc_pkg::ST_LR;
                                end else begin
                                    side_next = side_reg + 2'd1;
                                    step_next = msc_pkg::STEP_SS;
                                end
                            end else begin
                                step_next = msc_pkg::STEP_QW;
                            end
                        end
                        msc_pkg::STEP_QW: begin
                            step_next = (a_res < ss_reg) ? msc_pkg::STEP_T : msc_pkg::STEP_WW;
                        end
                        msc_pkg::STEP_WW:  step_next = msc_pkg::STEP_VAR;
                        msc_pkg::STEP_VAR: step_next = msc_pkg::STEP_T;
                        msc_pkg::STEP_T: begin
                            if (side_reg == msc_pkg::SIDE_RIGHT) begin
                                state_next = msc_pkg::ST_LR;
                            end else begin
                                side_next = side_reg + 2'd1;
                                step_next = msc_pkg::STEP_SS;
                            end
                        end
                        default: state_next = msc_pkg::ST_OUT;
                    endcase
                end
            end
            msc_pkg::ST_LR: begin
                state_next = msc_pkg::ST_ISSUE;
                step_next  = msc_pkg::STEP_IMP;
            end
            msc_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = msc_pkg::ST_IDLE;
                end
            end
            default: state_next = msc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= msc_pkg::ST_IDLE;
            step_reg  <= msc_pkg::STEP_SS;
            side_reg  <= msc_pkg::SIDE_NODE;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            side_reg  <= side_next;
        end
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wtot_reg <= msc_pkg::WTOT_RESET;
        end else if (cfg_we) begin
            wtot_reg <= cfg_wdata;
        end
    end

    // node and left sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            sp_reg  <= '0;
            nw_reg  <= '0;
            ns_reg  <= '0;
            nq_reg  <= '0;
            lw_reg  <= '0;
            ls_reg  <= '0;
            lq_reg  <= '0;
        end else begin
            case (state_reg)
                msc_pkg::ST_IDLE: begin
                    if (in_xfer && s_opcode == msc_pkg::OP_LOAD) begin
                        if (s_first_of_node) begin
                            sp_reg <= '0;
                            nw_reg <= '0;
                            ns_reg <= '0;
                            nq_reg <= '0;
                            lw_reg <= '0;
                            ls_reg <= '0;
                            lq_reg <= '0;
                        end
                        cnt_reg <= load_ok ? cnt_eff + CNT_W'(1) : cnt_eff;
                    end else if (in_xfer && !fwd_c) begin
                        lw_reg <= nw_reg;
                        ls_reg <= ns_reg;
                        lq_reg <= nq_reg;
                    end
                end
                msc_pkg::ST_LD_ACC: begin
                    nw_reg <= nw_reg + W_W'(opw_reg);
                    ns_reg <= ns_reg + S_W'(wy_reg);
                    nq_reg <= nq_reg + Q_W'(wyy_c);
                end
                msc_pkg::ST_WALK_RD: begin
                    if (ptr_reg == pos_reg) begin
                        sp_reg <= pos_reg;
                    end
                end
                msc_pkg::ST_WALK_ACC: begin
                    if (fwd_reg) begin
                        lw_reg <= lw_reg + W_W'(opw_reg);
                        ls_reg <= ls_reg + S_W'(wy_reg);
                        lq_reg <= lq_reg + Q_W'(wyy_c);
                    end else begin
                        lw_reg <= lw_reg - W_W'(opw_reg);
                        ls_reg <= ls_reg - S_W'(wy_reg);
                        lq_reg <= lq_reg - Q_W'(wyy_c);
                    end
                end
                default: ;
            endcase
        end
    end

    // query datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            msc_pkg::ST_IDLE: begin
                opw_reg   <= s_sample_weight;
                opy_reg   <= s_target;
                pos_reg   <= CNT_W'(pos_c);
                clamp_reg <= clamp_c;
                fwd_reg   <= fwd_c;
                ptr_reg   <= fwd_c ? sp_reg : cnt_reg;
            end
            msc_pkg::ST_LD_MUL: begin
                wy_reg <= wy_c;
                yy_reg <= $unsigned(yy_c);
            end
            msc_pkg::ST_WALK_RD: begin
                if (ptr_reg == pos_reg) begin
                    if (clamp_reg) begin
                        status_reg <= msc_pkg::STATUS_CLAMPED;
                    end else if (lw_reg == '0) begin
                        status_reg <= msc_pkg::STATUS_LEFT_EMPTY;
                    end else if (rw == '0) begin
                        status_reg <= msc_pkg::STATUS_RIGHT_EMPTY;
                    end else begin
                        status_reg <= msc_pkg::STATUS_OK;
                    end
                end else if (fwd_reg) begin
                    ptr_reg <= ptr_reg + CNT_W'(1);
                end else begin
                    ptr_reg <= ptr_reg - CNT_W'(1);
                end
            end
            msc_pkg::ST_WALK_MUL: begin
                opw_reg <= mul_w;
                wy_reg  <= wy_c;
                yy_reg  <= $unsigned(yy_c);
            end
            msc_pkg::ST_WAIT: begin
                if (a_done) begin
                    case (step_reg)
                        msc_pkg::STEP_SS: begin
                            ss_reg <= a_res;
                            if (w_zero) begin
                                var_reg[side_reg] <= '0;
                                t_reg[side_reg]   <= '0;
                            end
                        end
                        msc_pkg::STEP_QW: begin
                            qw_reg <= a_res;
                            if (a_res < ss_reg) begin
                                var_reg[side_reg] <= '0;
                            end
                        end
                        msc_pkg::STEP_WW:  ww_reg <= a_res[63:0];
                        msc_pkg::STEP_VAR: var_reg[side_reg] <= msc_pkg::sat64(a_res);
                        msc_pkg::STEP_T:   t_reg[side_reg] <= a_res;
                        default:           imp_reg <= imp_neg ? (OUT_W'(0) - imp_mag) : imp_mag;
                    endcase
                end
            end
            msc_pkg::ST_LR: lr_reg <= t_reg[1] + t_reg[2];
            default: ;
        endcase
    end

    // result register
    assign out_load = (state_reg == msc_pkg::ST_OUT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_node_reg   <= var_reg[0];
            m_left_reg   <= var_reg[1];
            m_right_reg  <= var_reg[2];
            m_proxy_reg  <= msc_pkg::sat64(lr_reg);
            m_imp_reg    <= imp_reg;
            m_status_reg <= status_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_parent_impurity   = $signed(m_node_reg);
    assign m_left_impurity     = $signed(m_left_reg);
    assign m_right_impurity    = $signed(m_right_reg);
    assign m_proxy_improvement = $signed(m_proxy_reg);
    assign m_improvement       = $signed(m_imp_reg);
    assign m_status            = m_status_reg;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for mse_split_criterion_unit: loads and split queries are driven
// over valid/ready with random idling, every query report is predicted by a
// bit-exact model of the weighted mse criterion and compared field by field.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic              opcode;
        logic              first;
        logic [15:0]       weight;
        logic [15:0]       target;
        logic [12:0]       position;
    } split_item_t;

    typedef struct {
        logic [63:0] node_imp;
        logic [63:0] left_imp;
        logic [63:0] right_imp;
        logic [63:0] proxy;
        logic [63:0] improve;
        logic [1:0]  status;
    } split_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [msc_pkg::WTOT_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_opcode = 1'b0;
    logic s_first_of_node = 1'b0;
    logic [msc_pkg::WEIGHT_W-1:0] s_sample_weight = '0;
    logic signed [msc_pkg::TARGET_W-1:0] s_target = '0;
    logic [msc_pkg::POS_W-1:0] s_split_position = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [msc_pkg::OUT_W-1:0] m_parent_impurity, m_left_impurity, m_right_impurity;
    logic signed [msc_pkg::OUT_W-1:0] m_proxy_improvement, m_improvement;
    logic [msc_pkg::STATUS_W-1:0] m_status;

    split_item_t   pending_items[$];
    split_report_t expected_reports[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int query_count = 0;
    int load_count = 0;

    // model state
    logic [31:0] mdl_store [0:4095];
    int          mdl_count;
    logic [63:0] mdl_nw, mdl_nq, mdl_lw, mdl_lq;
    longint      mdl_ns, mdl_ls;
    int          mdl_split;
    logic [63:0] mdl_wtot;

    always #4 aclk = ~aclk;

    mse_split_criterion_unit i_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_first_of_node(s_first_of_node), .s_sample_weight(s_sample_weight),
        .s_target(s_target), .s_split_position(s_split_position),
        .m_valid(m_valid), .m_ready(m_ready), .m_parent_impurity(m_parent_impurity),
        .m_left_impurity(m_left_impurity), .m_right_impurity(m_right_impurity),
        .m_proxy_improvement(m_proxy_improvement), .m_improvement(m_improvement),
        .m_status(m_status)
    );

    function automatic logic [63:0] clip64(input logic [127:0] v);
        return (v[127:63] != '0) ? msc_pkg::INT64_TOP : v[63:0];
    endfunction

    function automatic logic [63:0] magnitude(input longint s);
        return (s < 0) ? (64'd0 - 64'(s)) : 64'(s);
    endfunction

    function automatic logic [63:0] weighted_variance(input logic [63:0] q, input longint s,
                                                      input logic [63:0] w);
        logic [127:0] qw, ss, sa;
        if (w == 0) return 64'd0;
        sa = {64'd0, magnitude(s)};
        qw = {64'd0, q} * {64'd0, w};
        ss = sa * sa;
        if (qw < ss) return 64'd0;
        return clip64(((qw - ss) << 8) / ({64'd0, w} * {64'd0, w}));
    endfunction

    function automatic logic [127:0] square_over_weight(input longint s, input logic [63:0] w);
        logic [127:0] sa;
        if (w == 0) return 128'd0;
        sa = {64'd0, magnitude(s)};
        return (sa * sa) / {64'd0, w};
    endfunction

    task automatic move_sample(input logic [31:0] e, input bit add);
        logic [63:0] w, yy;
        longint y, wy;
        w = {48'd0, e[15:0]};
        y = longint'($signed(e[31:16]));
        wy = longint'(w) * y;
        yy = 64'(y * y);
        if (add) begin
            mdl_lw += w; mdl_ls += wy; mdl_lq += w * yy;
        end else begin
            mdl_lw -= w; mdl_ls -= wy; mdl_lq -= w * yy;
        end
    endtask

    task automatic split_model_step(input split_item_t it);
        int pos, p;
        logic [1:0] st;
        logic [63:0] rw, rq, wt, mag, w, yy;
        longint rs, y;
        logic [127:0] tl, tr, tn, lr, d;
        split_report_t r;
        if (it.opcode == msc_pkg::OP_LOAD) begin
            if (it.first) begin
                mdl_count = 0; mdl_nw = 0; mdl_ns = 0; mdl_nq = 0;
                mdl_split = 0; mdl_lw = 0; mdl_ls = 0; mdl_lq = 0;
            end
            if (mdl_count >= 4096) return;
            w = {48'd0, it.weight};
            y = longint'($signed(it.target));
            yy = 64'(y * y);
            mdl_store[mdl_count] = {it.target, it.weight};
            mdl_count++;
            mdl_nw += w; mdl_ns += longint'(w) * y; mdl_nq += w * yy;
            return;
        end
        st = msc_pkg::STATUS_OK;
        pos = it.position;
        if (pos > mdl_count) begin
            pos = mdl_count; st = msc_pkg::STATUS_CLAMPED;
        end
        if (pos >= mdl_split && pos - mdl_split <= mdl_count - pos) begin
            for (p = mdl_split; p < pos; p++) move_sample(mdl_store[p], 1'b1);
        end else begin
            mdl_lw = mdl_nw; mdl_ls = mdl_ns; mdl_lq = mdl_nq;
            for (p = mdl_count; p > pos; p--) move_sample(mdl_store[p-1], 1'b0);
        end
        mdl_split = pos;
        rw = mdl_nw - mdl_lw;
        rs = mdl_ns - mdl_ls;
        rq = mdl_nq - mdl_lq;
        if (st == msc_pkg::STATUS_OK) begin
            if (mdl_lw == 0) st = msc_pkg::STATUS_LEFT_EMPTY;
            else if (rw == 0) st = msc_pkg::STATUS_RIGHT_EMPTY;
        end
        r.node_imp = weighted_variance(mdl_nq, mdl_ns, mdl_nw);
        r.left_imp = weighted_variance(mdl_lq, mdl_ls, mdl_lw);
        r.right_imp = weighted_variance(rq, rs, rw);
        tl = square_over_weight(mdl_ls, mdl_lw);
        tr = square_over_weight(rs, rw);
        tn = square_over_weight(mdl_ns, mdl_nw);
        lr = tl + tr;
        r.proxy = clip64(lr);
        d = (lr < tn) ? tn - lr : lr - tn;
        wt = (mdl_wtot != 0) ? mdl_wtot : 64'd1;
        mag = clip64((d << 8) / {64'd0, wt});
        r.improve = (lr < tn) ? 64'd0 - mag : mag;
        r.status = st;
        expected_reports.push_back(r);
    endtask

    // driver
    always @(posedge aclk) begin
        split_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                it.opcode = s_opcode; it.first = s_first_of_node;
                it.weight = s_sample_weight; it.target = s_target;
                it.position = s_split_position;
                split_model_step(it);
                if (it.opcode == msc_pkg::OP_QUERY) query_count++;
                else load_count++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    it = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_opcode <= it.opcode;
                    s_first_of_node <= it.first;
                    s_sample_weight <= it.weight;
                    s_target <= it.target;
                    s_split_position <= it.position;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        split_report_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result transfer with no query outstanding");
                    error_count++;
                end else begin
                    e = expected_reports.pop_front();
                    if (m_parent_impurity !== e.node_imp) begin
                        $error("parent_impurity exp %0d got %0d", $signed(e.node_imp),
                               m_parent_impurity);
                        error_count++;
                    end
                    if (m_left_impurity !== e.left_imp) begin
                        $error("left_impurity exp %0d got %0d", $signed(e.left_imp),
                               m_left_impurity);
                        error_count++;
                    end
                    if (m_right_impurity !== e.right_imp) begin
                        $error("right_impurity exp %0d got %0d", $signed(e.right_imp),
                               m_right_impurity);
                        error_count++;
                    end
                    if (m_proxy_improvement !== e.proxy) begin
                        $error("proxy_improvement exp %0d got %0d", $signed(e.proxy),
                               m_proxy_improvement);
                        error_count++;
                    end
                    if (m_improvement !== e.improve) begin
                        $error("improvement exp %0d got %0d", $signed(e.improve),
                               m_improvement);
                        error_count++;
                    end
                    if (m_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, m_status);
                        error_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_load(input logic first, input logic [15:0] w, input logic [15:0] t);
        split_item_t it;
        it.opcode = msc_pkg::OP_LOAD; it.first = first; it.weight = w; it.target = t;
        it.position = 13'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic push_query(input logic [12:0] pos);
        split_item_t it;
        it.opcode = msc_pkg::OP_QUERY; it.first = 1'($urandom); it.weight = 16'($urandom);
        it.target = 16'($urandom); it.position = pos;
        pending_items.push_back(it);
    endtask

    function automatic logic [15:0] rand_weight();
        int k;
        k = $urandom_range(15);
        if (k == 0) return 16'd0;
        if (k == 1) return 16'hffff;
        if (k < 8) return 16'($urandom_range(1, 1023));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_target();
        int k;
        k = $urandom_range(15);
        if (k == 0) return 16'h8000;
        if (k == 1) return 16'h7fff;
        if (k < 6) return 16'($urandom_range(0, 511) - 256);
        return 16'($urandom);
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_valid || expected_reports.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_weight_total(input logic [msc_pkg::WTOT_W-1:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        mdl_wtot = {28'd0, v};
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // random nodes: mostly small, a few larger
    task automatic random_phase(input int n_items);
        int issued, size, k, qleft;
        issued = 0;
        while (issued < n_items) begin
            k = $urandom_range(99);
            if (k < 3) begin
                push_query(13'($urandom));
                issued++;
                continue;
            end
            size = (k < 90) ? $urandom_range(1, 12) : $urandom_range(13, 80);
            for (int i = 0; i < size; i++) begin
                push_load(i == 0, rand_weight(), rand_target());
                issued++;
                if ($urandom_range(99) < 20) begin
                    push_query(13'($urandom_range(0, i + 3)));
                    issued++;
                end
            end
            qleft = $urandom_range(1, 4);
            for (int j = 0; j < qleft; j++) begin
                push_query(13'($urandom_range(0, size + 1)));
                issued++;
            end
        end
    endtask

    initial begin
        mdl_count = 0; mdl_nw = 0; mdl_ns = 0; mdl_nq = 0;
        mdl_split = 0; mdl_lw = 0; mdl_ls = 0; mdl_lq = 0;
        mdl_wtot = 64'd256;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: empty node, field extremes, clamping, zero-weight node
        push_query(13'd0);
        push_query(13'd5);
        push_load(1'b1, 16'hffff, 16'h8000);
        push_load(1'b0, 16'h0000, 16'h7fff);
        push_load(1'b0, 16'h0100, 16'h0000);
        push_load(1'b0, 16'h0001, 16'hffff);
        push_query(13'd0);
        push_query(13'd4);
        push_query(13'd2);
        push_query(13'd1);
        push_query(13'd3);
        push_query(13'd9);
        push_query(13'h1fff);
        push_load(1'b1, 16'h0000, 16'h1234);
        push_load(1'b0, 16'h0000, 16'hedcb);
        push_query(13'd1);
        push_load(1'b1, 16'h8000, 16'h7fff);
        push_load(1'b0, 16'h8000, 16'h8000);
        push_query(13'd1);
        push_query(13'd0);
        push_query(13'd2);
        wait_idle();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0; recv_stall_pct = 0;
                    write_weight_total({msc_pkg::WTOT_W{1'b1}});
                end
                1: begin
                    send_idle_pct = 78; recv_stall_pct = 0;
                    write_weight_total(36'd1);
                end
                2: begin
                    send_idle_pct = 0; recv_stall_pct = 78;
                    write_weight_total(36'd0);
                end
                default: begin
                    send_idle_pct = 24; recv_stall_pct = 24;
                    write_weight_total(36'($urandom_range(1, 1 << 20)));
                end
            endcase
            random_phase(405);
            wait_idle();
        end
        $display("covered %0d loads and %0d split queries over four idling phases",
                 load_count, query_count);
        $display("dataset weight settings: reset, max, one, zero and a random value");
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== mse_split_criterion_unit.f =====
sv/msc_pkg.sv
sv/msc_ram.sv
sv/msc_arith.sv
sv/mse_split_criterion_unit.sv
tb/sv/tb_top.sv
